@@ rtl/core/aifp_pkg.sv @@
`default_nettype none

package aifp_pkg;

    // clamp applied to the field width register
    localparam int WIDTH_LIMIT_MAX = 255;

    // default number of classified items held between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [1:0] REG_RADIX_MODE = 2'd0;
    localparam logic [1:0] REG_MAX_WIDTH  = 2'd1;
    localparam logic [1:0] REG_STORE_SIZE = 2'd2;

    // store size codes
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    // characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;

    // radix selection, encoded as the radix_mode register
    typedef enum logic [1:0] {
        RAD_AUTO,
        RAD_OCT,
        RAD_DEC,
        RAD_HEX
    } radix_t;

    typedef struct packed {
        logic [1:0] radix_mode;
        logic [7:0] max_width;
        logic [1:0] store_size;
    } cfg_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               status;
        logic [15:0]        chars_used;
        logic [7:0]         stop_char;
        logic               stop_char_kept;
    } out_item_t;

    // classified character passed from front to back
    typedef struct packed {
        logic [7:0] char_byte;
        logic       eof;
        logic       space;
        logic       plus;
        logic       minus;
        logic       zero;
        logic       ex;
        logic       dvalid;
        logic [5:0] dval;
    } cls_t;

    // numeric radix, zero while still undecided
    function automatic logic [4:0] radix_value(radix_t r);
        logic [4:0] v;
        case (r)
            RAD_OCT: v = 5'd8;
            RAD_DEC: v = 5'd10;
            RAD_HEX: v = 5'd16;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ascii_integer_field_parser_unit.sv @@
// ascii integer field parser: one character item in, one result item per field.
// throughput: one character item per cycle while neither the queue nor the
// result register stalls, set by the single 64-bit shift-add of the accumulator
// in the back state machine. a character that ends a field is written into the
// queue, then captured in the result register.
// reset: asynchronous active low; config, queue pointers and parser state clear at once.
`default_nettype none

module ascii_integer_field_parser_unit #(
    parameter int QUEUE_DEPTH = aifp_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                char_valid,
    output logic                     char_ready,
    input  wire aifp_pkg::in_item_t  char_item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output aifp_pkg::out_item_t      result_item,
    input  wire logic                cfg_write,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [7:0]          cfg_data
);
    import aifp_pkg::*;

    cfg_t cfg_reg;
    cls_t push_item;
    cls_t pop_item;
    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radix_mode <= RAD_DEC;
            cfg_reg.max_width  <= '0;
            cfg_reg.store_size <= SIZE_32;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RADIX_MODE: cfg_reg.radix_mode <= cfg_data[1:0];
                REG_MAX_WIDTH:  cfg_reg.max_width  <= cfg_data;
                REG_STORE_SIZE: cfg_reg.store_size <= cfg_data[1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // classification
    aifp_front u_front (
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    // decoupling queue
    aifp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .pop       (q_pop),
        .pop_item  (pop_item)
    );

    // field parser and result register
    aifp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (pop_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

`default_nettype wire

@@ rtl/core/aifp_front.sv @@
`default_nettype none

module aifp_front (
    input  wire logic               char_valid,
    output logic                    char_ready,
    input  wire aifp_pkg::in_item_t char_item,
    input  wire logic               q_full,
    output logic                    q_push,
    output aifp_pkg::cls_t          q_item
);
    import aifp_pkg::*;

    logic [7:0] c;

    assign c = char_item.char_byte;

    // take an item whenever the queue has room
    assign char_ready = !q_full;
    assign q_push     = char_valid && !q_full;

    // character classes
    always_comb
    begin
        q_item           = '0;
        q_item.char_byte = c;
        q_item.eof       = char_item.end_of_input;
        q_item.space     = (c inside {CH_SPACE, [CH_TAB:CH_CR]});
        q_item.plus      = (c == CH_PLUS);
        q_item.minus     = (c == CH_MINUS);
        q_item.zero      = (c == CH_ZERO);
        q_item.ex        = (c inside {CH_LC_X, CH_UC_X});
        // digit value before any radix check
        if (c inside {[CH_ZERO:CH_NINE]})
        begin
            q_item.dvalid = 1'b1;
            q_item.dval   = 6'(c - CH_ZERO);
        end
        else if (c inside {[CH_LC_A:CH_LC_Z]})
        begin
            q_item.dvalid = 1'b1;
            q_item.dval   = 6'(c - CH_LC_A + 8'd10);
        end
        else if (c inside {[CH_UC_A:CH_UC_Z]})
        begin
            q_item.dvalid = 1'b1;
            q_item.dval   = 6'(c - CH_UC_A + 8'd10);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/aifp_queue.sv @@
`default_nettype none

module aifp_queue #(
    parameter int DEPTH = aifp_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire aifp_pkg::cls_t push_item,
    output logic                full,
    output logic                q_valid,
    input  wire logic           pop,
    output aifp_pkg::cls_t      pop_item
);
    import aifp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_count_rise: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue fill count did not follow a lone push");

    a_pop_filled: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

@@ rtl/core/aifp_back.sv @@
`default_nettype none

module aifp_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire aifp_pkg::cfg_t  cfg,
    input  wire logic            q_valid,
    output logic                 q_pop,
    input  wire aifp_pkg::cls_t  q_item,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output aifp_pkg::out_item_t  result_item
);
    import aifp_pkg::*;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGN,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS
    } phase_t;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    radix_t      radix_reg, radix_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        saw_reg, saw_next;
    logic [8:0]  used_reg, used_next;
    logic [7:0]  lim_reg, lim_next;
    logic        unl_reg, unl_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_acc_reg, out_acc_next;
    logic        out_neg_reg, out_neg_next;
    logic        out_saw_reg, out_saw_next;
    logic [15:0] out_cnt_reg, out_cnt_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic        out_kept_reg, out_kept_next;
    logic [1:0]  out_size_reg, out_size_next;

    logic        emit;
    logic        kept;
    logic        go_body;
    logic        go_digit;
    logic        digit_ok;
    logic [63:0] signed_acc;

    function automatic logic [15:0] sat_inc16(logic [15:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [8:0] sat_inc9(logic [8:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic limit_hit(logic [8:0] used, logic [7:0] lim, logic unl);
        return !unl && (used >= {1'b0, lim});
    endfunction

    // accumulator times radix by shifts, one multiply-add per character
    function automatic logic [63:0] scale(logic [63:0] a, radix_t r);
        logic [63:0] s;
        case (r)
            RAD_OCT: s = a << 3;
            RAD_DEC: s = (a << 3) + (a << 1);
            RAD_HEX: s = a << 4;
            default: s = '0;
        endcase
        return s;
    endfunction

    // take an item when the result register is free or being emptied
    assign q_pop = q_valid && (!out_valid_reg || result_ready);

    // next state of the parser
    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        radix_next     = radix_reg;
        cnt_next       = cnt_reg;
        saw_next       = saw_reg;
        used_next      = used_reg;
        lim_next       = lim_reg;
        unl_next       = unl_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_acc_next   = out_acc_reg;
        out_neg_next   = out_neg_reg;
        out_saw_next   = out_saw_reg;
        out_cnt_next   = out_cnt_reg;
        out_char_next  = out_char_reg;
        out_kept_next  = out_kept_reg;
        out_size_next  = out_size_reg;
        emit           = 1'b0;
        kept           = 1'b0;
        go_body        = 1'b0;
        go_digit       = 1'b0;
        digit_ok       = 1'b0;

        if (q_pop)
        begin
            case (phase_reg)
                PH_SKIP:
                begin
                    if (q_item.eof)
                    begin
                        emit = 1'b1;
                    end
                    else if (q_item.space)
                    begin
                        cnt_next = sat_inc16(cnt_next);
                    end
                    else
                    begin
                        // field starts: latch radix and width limit
                        radix_next = radix_t'(cfg.radix_mode);
                        unl_next   = (cfg.max_width == '0);
                        lim_next   = ({8'd0, cfg.max_width} < 16'(WIDTH_LIMIT_MAX)) ?
                                     cfg.max_width : 8'(WIDTH_LIMIT_MAX);
                        used_next  = 9'd1;
                        if (q_item.plus || q_item.minus)
                        begin
                            neg_next = q_item.minus;
                            if (limit_hit(used_next, lim_next, unl_next))
                            begin
                                emit = 1'b1;
                                kept = 1'b1;
                            end
                            else
                            begin
                                cnt_next   = sat_inc16(cnt_next);
                                phase_next = PH_SIGN;
                            end
                        end
                        else
                        begin
                            go_body = 1'b1;
                        end
                    end
                end
                PH_SIGN:
                begin
                    if (q_item.eof)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        used_next = sat_inc9(used_next);
                        go_body   = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    if (q_item.eof)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        used_next = sat_inc9(used_next);
                        if (q_item.ex)
                        begin
                            // hex prefix: the leading zero no longer counts as a digit
                            cnt_next   = sat_inc16(cnt_next);
                            radix_next = RAD_HEX;
                            saw_next   = 1'b0;
                            if (!limit_hit(used_next, lim_next, unl_next))
                            begin
                                phase_next = PH_PREFIX;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        else
                        begin
                            if (radix_next == RAD_AUTO)
                            begin
                                radix_next = RAD_OCT;
                            end
                            go_digit = 1'b1;
                        end
                    end
                end
                PH_PREFIX, PH_DIGITS:
                begin
                    if (q_item.eof)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        used_next = sat_inc9(used_next);
                        go_digit  = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase

            // first character after whitespace and sign
            if (go_body)
            begin
                if ((radix_next inside {RAD_AUTO, RAD_HEX}) && q_item.zero)
                begin
                    cnt_next = sat_inc16(cnt_next);
                    saw_next = 1'b1;
                    if (!limit_hit(used_next, lim_next, unl_next))
                    begin
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                else
                begin
                    if (radix_next == RAD_AUTO)
                    begin
                        radix_next = RAD_DEC;
                    end
                    go_digit = 1'b1;
                end
            end

            // digit in the resolved radix
            if (go_digit)
            begin
                digit_ok = q_item.dvalid && (q_item.dval < {1'b0, radix_value(radix_next)});
                if (!digit_ok)
                begin
                    emit = 1'b1;
                    kept = 1'b1;
                end
                else
                begin
                    cnt_next = sat_inc16(cnt_next);
                    acc_next = scale(acc_next, radix_next) + 64'(q_item.dval);
                    saw_next = 1'b1;
                    if (limit_hit(used_next, lim_next, unl_next))
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DIGITS;
                    end
                end
            end

            // result capture and start of the next field
            if (emit)
            begin
                out_valid_next = 1'b1;
                out_acc_next   = acc_next;
                out_neg_next   = neg_next;
                out_saw_next   = saw_next;
                out_cnt_next   = cnt_next;
                out_char_next  = kept ? q_item.char_byte : 8'd0;
                out_kept_next  = kept;
                out_size_next  = cfg.store_size;
                phase_next     = PH_SKIP;
                acc_next       = '0;
                neg_next       = 1'b0;
                radix_next     = radix_t'(cfg.radix_mode);
                cnt_next       = '0;
                saw_next       = 1'b0;
                used_next      = '0;
                lim_next       = '0;
                unl_next       = 1'b1;
            end
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            radix_reg     <= RAD_DEC;
            cnt_reg       <= '0;
            saw_reg       <= 1'b0;
            used_reg      <= '0;
            lim_reg       <= '0;
            unl_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
            out_acc_reg   <= '0;
            out_neg_reg   <= 1'b0;
            out_saw_reg   <= 1'b0;
            out_cnt_reg   <= '0;
            out_char_reg  <= '0;
            out_kept_reg  <= 1'b0;
            out_size_reg  <= SIZE_32;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            radix_reg     <= radix_next;
            cnt_reg       <= cnt_next;
            saw_reg       <= saw_next;
            used_reg      <= used_next;
            lim_reg       <= lim_next;
            unl_reg       <= unl_next;
            out_valid_reg <= out_valid_next;
            out_acc_reg   <= out_acc_next;
            out_neg_reg   <= out_neg_next;
            out_saw_reg   <= out_saw_next;
            out_cnt_reg   <= out_cnt_next;
            out_char_reg  <= out_char_next;
            out_kept_reg  <= out_kept_next;
            out_size_reg  <= out_size_next;
        end
    end

    // negate and sign-extend from the store size
    assign signed_acc = out_neg_reg ? (64'd0 - out_acc_reg) : out_acc_reg;

    always_comb
    begin
        result_item                = '0;
        result_item.status         = !out_saw_reg;
        result_item.chars_used     = out_cnt_reg;
        result_item.stop_char      = out_char_reg;
        result_item.stop_char_kept = out_kept_reg;
        if (out_saw_reg)
        begin
            case (out_size_reg)
                SIZE_8:  result_item.value = {{56{signed_acc[7]}}, signed_acc[7:0]};
                SIZE_16: result_item.value = {{48{signed_acc[15]}}, signed_acc[15:0]};
                SIZE_32: result_item.value = {{32{signed_acc[31]}}, signed_acc[31:0]};
                default: result_item.value = signed_acc;
            endcase
        end
    end

    assign result_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (!saw_reg && (acc_reg == '0) && (used_reg == '0)))
        else $error("field state not cleared while skipping whitespace");

    a_width_room: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg != PH_SKIP) && !unl_reg) |-> (used_reg < {1'b0, lim_reg}))
        else $error("field continued past its width limit");

    a_radix_known: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_PREFIX) || (phase_reg == PH_DIGITS)) |->
        ((radix_reg != RAD_AUTO) && ((phase_reg != PH_PREFIX) || (radix_reg == RAD_HEX))))
        else $error("digits taken without a resolved radix");
`endif

endmodule

`default_nettype wire
